// ===== rtl/smh_pkg.sv =====
// Package for the streaming hash block: payload word types, sequencer control
// structs, round constants, initial hash values and the sigma functions.
// No dependencies.
package smh_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LAST_SLOT   = 6'd63;
    localparam logic [5:0]  LEN_SLOT    = 6'd56;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [1:0]  LAST_PART   = 2'd3;

    typedef logic [7:0][31:0] t_hash;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } t_out_word;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] data_byte;
        logic       step_word;
    } t_sched_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_round_ctl;

    localparam t_hash HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

endpackage

// ===== rtl/smh_sched.sv =====
// Block buffer and message schedule: bytes shift in big-endian, then the same
// sixteen-word window rolls one schedule word per round.
// Depends on smh_pkg.
module smh_sched
    import smh_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_word
);

    logic [31:0] r_w [BLOCK_WORDS];
    logic [31:0] w_next;

    // next schedule word from the current window
    assign w_next = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];
    assign o_word = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[BLOCK_WORDS-1] <= {r_w[BLOCK_WORDS-1][23:0], i_ctl.data_byte};
        end else if (i_ctl.step_word) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= w_next;
        end
    end

endmodule

// ===== rtl/smh_round.sv =====
// Compression round unit: holds the eight working variables and applies one
// round per step. Depends on smh_pkg.
module smh_round
    import smh_pkg::*;
(
    input  logic        i_clk,
    input  t_round_ctl  i_ctl,
    input  t_hash       i_chain,
    input  logic [31:0] i_k,
    input  logic [31:0] i_w,
    output t_hash       o_vars
);

    t_hash       r_v;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + big_sig1(r_v[4]) + ch + i_k + i_w;
        t2  = big_sig0(r_v[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_chain;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_vars = r_v;

endmodule

// ===== rtl/sha256_message_hash.sv =====
// Streaming SHA-256: byte packer and padding sequencer, chain value, digest out.
// Depends on smh_pkg, smh_sched and smh_round.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   input    | in        | i_valid / o_ready  | i_data (t_in_word), one byte
//   result   | out       | o_valid / i_ready  | o_data (t_out_word), 64 bits
//
// Flow: byte words go in one per cycle while o_ready is high; the 64th byte of a
// block starts the rounds (ST_COMP) and then the fold (ST_FOLD), during which
// o_ready is low. The block rate is set by the single round unit.
// End of message: one pad or length byte per cycle up to the block end, then its
// compression; a pad that leaves no room for the length adds one more block.
// Then four result words, one per cycle when i_ready.
// Reset (i_rst_n low, synchronous) loads the initial hash values and clears the
// byte slot, bit length and sequencer; the block buffer is not reset.
// A stalled result holds the sequencer; no input is taken until all four go.
module sha256_message_hash
    import smh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_FOLD = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_hash       r_chain, n_chain;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_bits, n_bits;
    logic [5:0]  r_rnd, n_rnd;
    logic [1:0]  r_part, n_part;
    logic        r_pad, n_pad;          // message ended, padding in progress
    logic        r_pad_first, n_pad_first;
    logic        r_len_ok, n_len_ok;    // current block has room for the length
    logic        r_fin, n_fin;          // current compression is the last one

    t_sched_ctl  sched_ctl;
    t_round_ctl  round_ctl;
    logic [31:0] sched_word;
    t_hash       work_vars;
    logic        in_acc;
    logic        out_acc;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    smh_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .o_word (sched_word)
    );

    smh_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (round_ctl),
        .i_chain (r_chain),
        .i_k     (ROUND_K[r_rnd]),
        .i_w     (sched_word),
        .o_vars  (work_vars)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Big-endian length byte for slots 56..63; slot offset picks the byte.
    assign len_byte = 8'(r_bits >> {~r_pos[2:0], 3'b000});
    assign pad_byte = r_pad_first ? PAD_BYTE :
                      (r_len_ok && (r_pos >= LEN_SLOT)) ? len_byte : 8'h00;

    always_comb begin
        o_data.digest_part = {r_chain[{r_part, 1'b0}], r_chain[{r_part, 1'b1}]};
        o_data.part_index  = r_part;
        o_data.last_part   = (r_part == LAST_PART);
    end

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_pos       = r_pos;
        n_bits      = r_bits;
        n_rnd       = r_rnd;
        n_part      = r_part;
        n_pad       = r_pad;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_fin       = r_fin;
        sched_ctl   = '{shift_byte: 1'b0, data_byte: i_data.data_byte, step_word: 1'b0};
        round_ctl   = '{load: 1'b0, step: 1'b0};

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_data.end_of_message) begin
                        n_pad       = 1'b1;
                        n_pad_first = 1'b1;
                        n_state     = ST_PAD;
                    end
                    if (i_data.has_byte) begin
                        sched_ctl.shift_byte = 1'b1;
                        n_bits = r_bits + 64'd8;
                        n_pos  = r_pos + 6'd1;
                        if (r_pos == LAST_SLOT) begin
                            // full block: compress now, pad afterwards if ended
                            round_ctl.load = 1'b1;
                            n_rnd   = '0;
                            n_fin   = 1'b0;
                            n_state = ST_COMP;
                        end
                    end
                end
            end
            ST_PAD: begin
                sched_ctl.shift_byte = 1'b1;
                sched_ctl.data_byte  = pad_byte;
                n_pos = r_pos + 6'd1;
                if (r_pad_first) begin
                    n_pad_first = 1'b0;
                    n_len_ok    = (r_pos < LEN_SLOT);
                end
                if (r_pos == LAST_SLOT) begin
                    round_ctl.load = 1'b1;
                    n_rnd    = '0;
                    n_fin    = !r_pad_first && r_len_ok;
                    n_len_ok = 1'b1;
                    n_state  = ST_COMP;
                end
            end
            ST_COMP: begin
                round_ctl.step      = 1'b1;
                sched_ctl.step_word = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + work_vars[i];
                end
                if (r_fin) begin
                    n_part  = '0;
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_part = r_part + 2'd1;
                    if (r_part == LAST_PART) begin
                        // drop the message state and restart the chain
                        n_chain = HASH_INIT;
                        n_bits  = '0;
                        n_pos   = '0;
                        n_pad   = 1'b0;
                        n_fin   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= HASH_INIT;
            r_pos       <= '0;
            r_bits      <= '0;
            r_rnd       <= '0;
            r_part      <= '0;
            r_pad       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_pos       <= n_pos;
            r_bits      <= n_bits;
            r_rnd       <= n_rnd;
            r_part      <= n_part;
            r_pad       <= n_pad;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_fin       <= n_fin;
        end
    end

`ifndef NO_ASSERTIONS
    // a compression always starts on a block boundary
    a_comp_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_rnd == 6'd0) |-> (r_pos == 6'd0))
        else $error("compression started off a block boundary");

    // results only appear after the final compression was folded in
    a_out_after_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_FOLD && r_part == 2'd0))
        else $error("digest shown without a final fold");

    // the last result clears the message length and slot
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_data.last_part) |=> (r_bits == 64'd0 && r_pos == 6'd0 && o_ready))
        else $error("message state not cleared after digest");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_message_hash: a queue-fed byte driver, a digest
// monitor and a SHA-256 predictor of its own. Depends on smh_pkg and the RTL top.
module tb_top
    import smh_pkg::*;
();

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 11;
    localparam int          MAX_WAIT     = 17;
    localparam int          TARGET_ITEMS = 480;
    localparam int          LONG_HOLD    = 700;
    localparam int          HOLD_AT_PART = 10;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          REPORT_CAP   = 40;
    localparam logic [7:0]  PAD_MARK     = 8'h80;
    localparam int          LEN_ROOM     = 55;
    localparam int          DIGEST_PARTS = 4;

    // Round constants and initial chain value of the standard hash.
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // DUT ports: every input known from time zero.
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    sha256_message_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state: running chain value, block buffer, byte slot, bit count.
    logic [31:0] hash_state [8];
    logic [31:0] msg_block [16];
    logic [5:0]  slot;
    logic [63:0] bit_count;

    t_in_word  byte_q [$];      // words waiting to be offered
    t_out_word digest_q [$];    // digest parts still owed by the block

    int fail_count     = 0;
    int words_sent     = 0;
    int parts_checked  = 0;
    int messages_hashed = 0;
    int cycle_count    = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fail_count < REPORT_CAP)
            $display("MISMATCH %0s: got %h want %h (part %0d)", what, got, want, parts_checked);
        fail_count++;
    endtask

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = msg_block[r];
        for (int r = 16; r < 64; r++)
            w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + SHA_K[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // Drop one byte into its big-endian slot; the first byte of a word clears it.
    task automatic place_byte(input logic [5:0] pos, input logic [7:0] value);
        int sh;
        sh = 24 - 8 * int'(pos[1:0]);
        if (pos[1:0] == 2'd0)
            msg_block[pos[5:2]] = {value, 24'h0};
        else
            msg_block[pos[5:2]] |= {24'h0, value} << sh;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = SHA_H0[i];
        slot      = '0;
        bit_count = '0;
    endtask

    // Advance the predictor by one accepted word; queue the digest on end of message.
    task automatic hash_word(input t_in_word it);
        t_out_word part;
        if (it.has_byte) begin
            place_byte(slot, it.data_byte);
            bit_count += 64'd8;
            slot = slot + 6'd1;
            if (slot == 6'd0)
                compress_block();
        end
        if (it.end_of_message) begin
            place_byte(slot, PAD_MARK);
            for (int wi = int'(slot[5:2]) + 1; wi < 16; wi++)
                msg_block[wi] = '0;
            // Pad overflow: length goes into an extra block.
            if (int'(slot) > LEN_ROOM) begin
                compress_block();
                for (int wi = 0; wi < 16; wi++)
                    msg_block[wi] = '0;
            end
            msg_block[14] = bit_count[63:32];
            msg_block[15] = bit_count[31:0];
            compress_block();
            for (int k = 0; k < DIGEST_PARTS; k++) begin
                part.digest_part = {hash_state[2*k], hash_state[2*k+1]};
                part.part_index  = 2'(k);
                part.last_part   = (k == DIGEST_PARTS - 1);
                digest_q = {digest_q, part};
            end
            messages_hashed++;
            restart_hash();
        end
    endtask

    task automatic check_digest(input t_out_word got);
        t_out_word want;
        if (digest_q.size() == 0) begin
            report("unexpected digest part", got.digest_part, '0);
        end else begin
            want = digest_q.pop_front();
            if (got.digest_part !== want.digest_part)
                report("digest_part", got.digest_part, want.digest_part);
            if (got.part_index !== want.part_index)
                report("part_index", 64'(got.part_index), 64'(want.part_index));
            if (got.last_part !== want.last_part)
                report("last_part", 64'(got.last_part), 64'(want.last_part));
        end
    endtask

    // Stimulus helpers: append one word to the pending queue.
    task automatic push_word(input logic [7:0] value, input logic has, input logic eom);
        t_in_word it;
        it.data_byte      = value;
        it.has_byte       = has;
        it.end_of_message = eom;
        byte_q = {byte_q, it};
    endtask

    // One message of len bytes with random content, noise words sprinkled in,
    // ended either on its last byte or by a separate end word.
    task automatic push_message(input int len, inout int counted);
        bit sep_end;
        sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                counted++;
            end
            push_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !sep_end);
            counted++;
        end
        if (sep_end) begin
            push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            counted++;
        end
    endtask

    // Driver: offer pending words, hold each until accepted, then wait its gap.
    int  tx_gap   = 0;
    bit  tx_burst = 1'b0;

    always @(posedge i_clk) begin : drive_proc
        bit take;
        take = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (take) begin
                hash_word(i_data);
                words_sent++;
            end
            if (i_valid && !take) begin
                // hold the offered word
            end else if (tx_gap > 0) begin
                i_valid <= 1'b0;
                tx_gap  <= tx_gap - 1;
            end else if (byte_q.size() > 0) begin
                i_data  <= byte_q.pop_front();
                i_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_gap <= tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted digest part and stall ready at random.
    int  rx_hold  = 0;
    bit  rx_burst = 1'b0;

    always @(posedge i_clk) begin : monitor_proc
        int hold_next;
        hold_next = rx_hold;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_digest(o_data);
                parts_checked++;
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                hold_next = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
                // One long back-pressure stretch so the input side fills and stalls.
                if (parts_checked == HOLD_AT_PART)
                    hold_next = LONG_HOLD;
            end
            if (hold_next > 0) begin
                i_ready <= 1'b0;
                rx_hold <= hold_next - 1;
            end else begin
                i_ready <= 1'b1;
                rx_hold <= 0;
            end
        end
    end

    // Watchdog on a generous cycle budget.
    always @(posedge i_clk) begin : watchdog_proc
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d digest parts still owed",
                     cycle_count, digest_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus_proc
        int counted;
        int len;
        int pick;
        int forced [5];
        int words_total;
        counted = 0;
        forced  = '{55, 56, 63, 64, 120};
        restart_hash();

        // Directed: empty message, ignored words, byte extremes, a classic short
        // message and an end marker on a word without a byte.
        push_word(8'hFF, 1'b0, 1'b1);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
        push_word(8'h00, 1'b1, 1'b1);
        push_word(8'hFF, 1'b1, 1'b1);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h62, 1'b1, 1'b0);
        push_word(8'h63, 1'b1, 1'b1);
        push_word(8'h5A, 1'b1, 1'b0);
        push_word(8'hA5, 1'b0, 1'b0);
        push_word(8'hC3, 1'b0, 1'b1);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'h00, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        counted = 15;

        // Random: first the pad and block boundaries, then a spread of lengths.
        for (int i = 0; i < 5; i++)
            push_message(forced[i], counted);
        while (counted < TARGET_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3)       len = $urandom_range(0, 12);
            else if (pick == 4)  len = $urandom_range(52, 58);
            else if (pick == 5)  len = $urandom_range(60, 66);
            else if (pick == 6)  len = $urandom_range(118, 130);
            else                 len = $urandom_range(13, 50);
            // trim the last message so the total stays near the target
            if (len > TARGET_ITEMS - counted)
                len = TARGET_ITEMS - counted;
            push_message(len, counted);
        end
        words_total = byte_q.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in, then for every digest part to come out.
        while (words_sent < words_total)
            @(posedge i_clk);
        while (digest_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages from %0d words, %0d digest parts checked,",
                 messages_hashed, words_sent, parts_checked);
        $display("with random idling on both sides and one long result stall.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
